### rtl/core/lsd_pkg.sv
// Shared constants, types and helpers for the least-loaded server dispatcher.
`default_nettype none
package lsd_pkg;

    localparam int MAX_SERVERS = 16;
    localparam int IDX_W       = $clog2(MAX_SERVERS);
    localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
    localparam int DATA_W      = 32;
    localparam int IN_W        = 16;
    localparam int CFG_W       = 5;
    localparam int OUT_IDX_W   = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPD
    } t_state;

    // one server entry: finish time and value total
    typedef struct packed {
        logic [DATA_W-1:0] fin;
        logic [DATA_W-1:0] val;
    } t_word;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_word            wr_data;
    } t_ram_req;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    fin;
        logic [DATA_W-1:0]    val;
        logic [DATA_W-1:0]    max;
    } t_result;

    // servers in use: zero reads as one, above the built maximum clamps
    function automatic logic [CNT_W-1:0] clamp_servers(input logic [CFG_W-1:0] c);
        logic [CNT_W-1:0] n;
        if (c == '0) begin
            n = CNT_W'(1);
        end else if (32'(c) > MAX_SERVERS) begin
            n = CNT_W'(MAX_SERVERS);
        end else begin
            n = CNT_W'(c);
        end
        return n;
    endfunction

    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [IN_W-1:0]   b);
        logic [DATA_W:0] s;
        s = {1'b0, a} + (DATA_W + 1)'(b);
        return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/core/lsd_ram.sv
// Server table memory with per-entry valid bits; unwritten entries read as zero.
`default_nettype none
module lsd_ram (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lsd_pkg::t_ram_req i_req,
    output lsd_pkg::t_word        o_rdata
);
    import lsd_pkg::*;

    t_word                  r_mem [MAX_SERVERS];
    t_word                  r_rdata;
    logic [MAX_SERVERS-1:0] r_vld;
    logic                   r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule
`default_nettype wire

### rtl/core/lsd_engine.sv
// Dispatch sequencer: fill or minimum scan over the table, then read-modify-write.
`default_nettype none
module lsd_engine (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [lsd_pkg::CNT_W-1:0] i_num_srv,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [lsd_pkg::IN_W-1:0]  i_service_time,
    input  wire logic [lsd_pkg::IN_W-1:0]  i_job_value,
    output logic                           o_res_vld,
    input  wire logic                      i_res_rdy,
    output lsd_pkg::t_result               o_res,
    output lsd_pkg::t_ram_req              o_req,
    input  wire lsd_pkg::t_word            i_rdata
);
    import lsd_pkg::*;

    t_state            r_state,   n_state;
    logic [IN_W-1:0]   r_t,       n_t;
    logic [IN_W-1:0]   r_v,       n_v;
    logic [IDX_W-1:0]  r_idx,     n_idx;
    logic [IDX_W-1:0]  r_end,     n_end;
    logic              r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic              r_first,   n_first;
    t_word             r_best,    n_best;
    logic [IDX_W-1:0]  r_sel,     n_sel;
    logic [CNT_W-1:0]  r_jobs,    n_jobs;
    logic [DATA_W-1:0] r_max,     n_max;

    logic [CNT_W-1:0]  num_m1;
    logic [DATA_W-1:0] new_fin;
    logic [DATA_W-1:0] new_val;
    logic [DATA_W-1:0] new_max;

    assign num_m1  = i_num_srv - CNT_W'(1);
    assign new_fin = sat_add(r_best.fin, r_t);
    assign new_val = sat_add(r_best.val, r_v);
    assign new_max = (new_fin > r_max) ? new_fin : r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cmp_vld <= 1'b0;
            r_jobs    <= '0;
            r_max     <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_jobs    <= n_jobs;
            r_max     <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t       <= n_t;
        r_v       <= n_v;
        r_idx     <= n_idx;
        r_end     <= n_end;
        r_cmp_idx <= n_cmp_idx;
        r_first   <= n_first;
        r_best    <= n_best;
        r_sel     <= n_sel;
    end

    always_comb begin
        n_state   = r_state;
        n_t       = r_t;
        n_v       = r_v;
        n_idx     = r_idx;
        n_end     = r_end;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_first   = r_first;
        n_best    = r_best;
        n_sel     = r_sel;
        n_jobs    = r_jobs;
        n_max     = r_max;
        o_in_ready    = 1'b0;
        o_res_vld     = 1'b0;
        o_req.rd_en   = 1'b0;
        o_req.rd_addr = r_idx;
        o_req.wr_en   = 1'b0;
        o_req.wr_addr = r_sel;
        o_req.wr_data = '{fin: new_fin, val: new_val};

        // compare the word that returned from the read issued last cycle
        if (r_cmp_vld && (r_first || (i_rdata.fin < r_best.fin))) begin
            n_best  = i_rdata;
            n_sel   = r_cmp_idx;
            n_first = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_t     = i_service_time;
                    n_v     = i_job_value;
                    n_first = 1'b1;
                    if (r_jobs < i_num_srv) begin
                        // fill phase: the next unused server, a one-entry scan
                        n_idx  = r_jobs[IDX_W-1:0];
                        n_end  = r_jobs[IDX_W-1:0];
                        n_jobs = r_jobs + CNT_W'(1);
                    end else begin
                        n_idx = '0;
                        n_end = num_m1[IDX_W-1:0];
                    end
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_req.rd_en = 1'b1;
                n_cmp_vld   = 1'b1;
                n_cmp_idx   = r_idx;
                if (r_idx == r_end) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                o_res_vld = 1'b1;
                if (i_res_rdy) begin
                    o_req.wr_en = 1'b1;
                    n_max       = new_max;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res.idx = OUT_IDX_W'(r_sel);
    assign o_res.fin = new_fin;
    assign o_res.val = new_val;
    assign o_res.max = new_max;

endmodule
`default_nettype wire

### rtl/core/least_loaded_server_dispatch.sv
// Top level of the least-loaded server dispatcher: config, table, sequencer, output word.
// Flow: a job scans k entries (k is 1 in the fill phase, else the servers in use), then
//   passes a drain state and an update state that waits for a free output slot.
// Jobs: one at a time, paced by the one-entry-per-cycle minimum scan over the server
//   table memory; the next job is accepted while the previous result word still
//   waits in the output register.
// Reset: synchronous, active low; the table valid bits clear at once, so no sweep.
`default_nettype none
module least_loaded_server_dispatch (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lsd_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [lsd_pkg::IN_W-1:0]      i_service_time,
    input  wire logic [lsd_pkg::IN_W-1:0]      i_job_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [lsd_pkg::OUT_IDX_W-1:0]      o_server_index,
    output logic [lsd_pkg::DATA_W-1:0]         o_server_finish_time,
    output logic [lsd_pkg::DATA_W-1:0]         o_server_value_total,
    output logic [lsd_pkg::DATA_W-1:0]         o_max_finish_time
);
    import lsd_pkg::*;

    // num_servers register; always ready; write it only while idle, the block does not enforce this
    logic [CFG_W-1:0] r_cfg;
    logic [CNT_W-1:0] num_srv;

    t_ram_req ram_req;
    t_word    ram_rdata;
    t_result  eng_res;
    logic     eng_res_vld;
    logic     eng_res_rdy;

    // output word register, parts the sequencer from the downstream stall
    logic    r_out_vld;
    t_result r_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    assign num_srv = clamp_servers(r_cfg);

    lsd_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    lsd_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_num_srv      (num_srv),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_service_time (i_service_time),
        .i_job_value    (i_job_value),
        .o_res_vld      (eng_res_vld),
        .i_res_rdy      (eng_res_rdy),
        .o_res          (eng_res),
        .o_req          (ram_req),
        .i_rdata        (ram_rdata)
    );

    // the slot is free when empty or being drained this cycle
    assign eng_res_rdy = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (eng_res_rdy) begin
            r_out_vld <= eng_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_res_rdy && eng_res_vld) begin
            r_out <= eng_res;
        end
    end

    assign o_out_valid          = r_out_vld;
    assign o_server_index       = r_out.idx;
    assign o_server_finish_time = r_out.fin;
    assign o_server_value_total = r_out.val;
    assign o_max_finish_time    = r_out.max;

    // running maximum always covers the finish time reported with it
    a_max_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_max_finish_time >= o_server_finish_time))
        else $error("max finish below reported finish");

    // one job at a time: the sequencer is busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a job is in flight");

    // a new output word only comes from a finished job
    a_word_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(eng_res_vld))
        else $error("output word without a finished job");

endmodule
`default_nettype wire
